// File: rtl/ptlp_pkg.sv
// ----------------------------------------------------------------------------
// ptlp_pkg: shared widths and types for the point-to-line projection core
// Field widths follow from the coordinate width; the division lane type is
// passed between the top level and the divider pipeline.
// ----------------------------------------------------------------------------
package ptlp_pkg;

   localparam int COORD_BITS = 16;

   // end - start and point - start, signed
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   // dot product (p - s).v, signed
   localparam int DOT_W  = PROD_W + 1;
   // magnitudes
   localparam int DMAG_W = COORD_BITS;
   localparam int TMAG_W = DOT_W - 1;
   localparam int TLO_W  = TMAG_W / 2;
   localparam int THI_W  = TMAG_W - TLO_W;
   localparam int NUM_W  = DMAG_W + TMAG_W;
   // |v|^2
   localparam int DEN_W  = 2 * COORD_BITS + 1;
   // quotient never exceeds |p - s|, so it fits one bit above a coordinate
   localparam int QUO_W  = COORD_BITS + 1;
   localparam int SUM_W  = QUO_W + 2;

   localparam int REQ_W  = ((6 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_W  = ((2 * COORD_BITS + 1 + 7) / 8) * 8;

   localparam logic signed [SUM_W-1:0] FOOT_MAX = SUM_W'(2**(COORD_BITS-1) - 1);
   localparam logic signed [SUM_W-1:0] FOOT_MIN = SUM_W'(-(2**(COORD_BITS-1)));

   typedef struct packed {
      logic                         horiz;
      logic                         neg_x;
      logic                         neg_y;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] point_x;
   } ptlp_side_type;

   // rem holds the partial remainder; low holds numerator bits still to be
   // shifted in, and fills with quotient bits from the bottom
   typedef struct packed {
      logic [DEN_W-1:0] rem_x;
      logic [QUO_W-1:0] low_x;
      logic [DEN_W-1:0] rem_y;
      logic [QUO_W-1:0] low_y;
      logic [DEN_W-1:0] den;
      ptlp_side_type    side;
   } ptlp_div_type;

endpackage

// File: rtl/ptlp_divider.sv
// ----------------------------------------------------------------------------
// ptlp_divider: pipelined restoring divider, two lanes sharing one divisor
// One quotient bit per stage for both axes; the sideband travels alongside.
// ----------------------------------------------------------------------------
module ptlp_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  ptlp_pkg::ptlp_div_type in_data,
   output logic                   out_valid,
   output ptlp_pkg::ptlp_div_type out_data
);

   function automatic logic [ptlp_pkg::DEN_W+ptlp_pkg::QUO_W-1:0] div_step(
      input logic [ptlp_pkg::DEN_W-1:0] rem,
      input logic [ptlp_pkg::QUO_W-1:0] low,
      input logic [ptlp_pkg::DEN_W-1:0] den
   );
      logic [ptlp_pkg::DEN_W:0]   trial;
      logic [ptlp_pkg::DEN_W:0]   diff;
      logic [ptlp_pkg::DEN_W-1:0] rem_nx;
      logic [ptlp_pkg::QUO_W-1:0] low_nx;
      trial = {rem, low[ptlp_pkg::QUO_W-1]};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         rem_nx = diff[ptlp_pkg::DEN_W-1:0];
         low_nx = {low[ptlp_pkg::QUO_W-2:0], 1'b1};
      end else begin
         rem_nx = trial[ptlp_pkg::DEN_W-1:0];
         low_nx = {low[ptlp_pkg::QUO_W-2:0], 1'b0};
      end
      return {rem_nx, low_nx};
   endfunction

   function automatic ptlp_pkg::ptlp_div_type advance(input ptlp_pkg::ptlp_div_type d);
      ptlp_pkg::ptlp_div_type r;
      r = d;
      {r.rem_x, r.low_x} = div_step(d.rem_x, d.low_x, d.den);
      {r.rem_y, r.low_y} = div_step(d.rem_y, d.low_y, d.den);
      return r;
   endfunction

   logic [ptlp_pkg::QUO_W-1:0] vld_ff;
   logic [ptlp_pkg::QUO_W-1:0] vld_in;
   ptlp_pkg::ptlp_div_type     stage_ff [ptlp_pkg::QUO_W];
   ptlp_pkg::ptlp_div_type     stage_in [ptlp_pkg::QUO_W];

   assign vld_in = {vld_ff[ptlp_pkg::QUO_W-2:0], in_valid};

   for (genvar k = 0; k < ptlp_pkg::QUO_W; k++) begin : g_step
      if (k == 0) begin : g_first
         assign stage_in[k] = advance(in_data);
      end else begin : g_next
         assign stage_in[k] = advance(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = vld_ff[ptlp_pkg::QUO_W-1];
   assign out_data  = stage_ff[ptlp_pkg::QUO_W-1];

endmodule

// File: rtl/point_to_line_projection_core.sv
// ----------------------------------------------------------------------------
// point_to_line_projection_core: foot of the perpendicular from a point
// onto a 2-D line, exact integer arithmetic
//
// Takes one transfer per cycle unless the result side stalls, and returns one
// result per transfer, in order, after five stages of differences, products
// and magnitudes, one stage per quotient bit in the restoring divider, and
// the output register; throughput is one item every cycle without a stall.
// A stall on the result side freezes the whole pipeline, and req_tready
// drops only while a result waits untaken.
// A horizontal line (equal start and end y) yields (point_x, start_y);
// otherwise each coordinate of start + v*t/|v|^2 is truncated toward zero and
// saturated, with clipped set when either saturates.
// ----------------------------------------------------------------------------
module point_to_line_projection_core (
   input  logic                       clock,
   input  logic                       reset,
   // start_x, start_y, end_x, end_y, point_x, point_y
   input  logic [ptlp_pkg::REQ_W-1:0] req_tdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // foot_x, foot_y, clipped, zero padding
   output logic [ptlp_pkg::RSP_W-1:0] rsp_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready
);

   localparam int CB = ptlp_pkg::COORD_BITS;

   function automatic logic [CB:0] foot_axis(
      input logic signed [CB-1:0]          s,
      input logic [ptlp_pkg::QUO_W-1:0]    q,
      input logic                          rnz,
      input logic                          neg
   );
      logic signed [ptlp_pkg::SUM_W-1:0] s_ext;
      logic signed [ptlp_pkg::SUM_W-1:0] q_ext;
      logic signed [ptlp_pkg::SUM_W-1:0] m;
      logic                              clip;
      s_ext = ptlp_pkg::SUM_W'(s);
      q_ext = $signed({2'b00, q});
      clip  = 1'b0;
      if (!neg) begin
         m = s_ext + q_ext;
         // truncate toward zero: a negative sum rounded down, pull it back
         if (m[ptlp_pkg::SUM_W-1] && rnz) begin
            m = m + ptlp_pkg::SUM_W'(1);
         end
      end else begin
         m = s_ext - q_ext;
         if (!m[ptlp_pkg::SUM_W-1] && (m != '0) && rnz) begin
            m = m - ptlp_pkg::SUM_W'(1);
         end
      end
      if (m > ptlp_pkg::FOOT_MAX) begin
         m    = ptlp_pkg::FOOT_MAX;
         clip = 1'b1;
      end else if (m < ptlp_pkg::FOOT_MIN) begin
         m    = ptlp_pkg::FOOT_MIN;
         clip = 1'b1;
      end
      return {clip, m[CB-1:0]};
   endfunction

   logic pipe_en;

   // input field split
   logic signed [CB-1:0] req_sx, req_sy, req_ex, req_ey, req_px, req_py;

   assign req_sx = $signed(req_tdata[0*CB +: CB]);
   assign req_sy = $signed(req_tdata[1*CB +: CB]);
   assign req_ex = $signed(req_tdata[2*CB +: CB]);
   assign req_ey = $signed(req_tdata[3*CB +: CB]);
   assign req_px = $signed(req_tdata[4*CB +: CB]);
   assign req_py = $signed(req_tdata[5*CB +: CB]);

   // stage 1: differences
   logic                                s1_vld_ff;
   logic                                s1_horiz_in;
   ptlp_pkg::ptlp_side_type             s1_side_ff, s1_side_in;
   logic signed [ptlp_pkg::DIFF_W-1:0]  s1_dx_ff, s1_dx_in, s1_dy_ff, s1_dy_in;
   logic signed [ptlp_pkg::DIFF_W-1:0]  s1_ux_ff, s1_ux_in, s1_uy_ff, s1_uy_in;

   // stage 2: products
   logic                                s2_vld_ff;
   ptlp_pkg::ptlp_side_type             s2_side_ff;
   logic signed [ptlp_pkg::DIFF_W-1:0]  s2_dx_ff, s2_dy_ff;
   logic signed [ptlp_pkg::PROD_W-1:0]  s2_pxx_ff, s2_pxx_in, s2_pyy_ff, s2_pyy_in;
   logic signed [ptlp_pkg::PROD_W-1:0]  s2_dxx_ff, s2_dxx_in, s2_dyy_ff, s2_dyy_in;

   // stage 3: dot product and squared length
   logic                                s3_vld_ff;
   ptlp_pkg::ptlp_side_type             s3_side_ff;
   logic signed [ptlp_pkg::DIFF_W-1:0]  s3_dx_ff, s3_dy_ff;
   logic signed [ptlp_pkg::DOT_W-1:0]   s3_t_ff, s3_t_in;
   logic [ptlp_pkg::DEN_W-1:0]          s3_den_ff, s3_den_in;
   logic [ptlp_pkg::DEN_W:0]            den_sum;

   // stage 4: magnitudes and partial products
   logic                                s4_vld_ff;
   ptlp_pkg::ptlp_side_type             s4_side_ff, s4_side_in;
   logic [ptlp_pkg::DEN_W-1:0]          s4_den_ff;
   logic [ptlp_pkg::DMAG_W+ptlp_pkg::TLO_W-1:0] s4_plo_x_ff, s4_plo_x_in;
   logic [ptlp_pkg::DMAG_W+ptlp_pkg::TLO_W-1:0] s4_plo_y_ff, s4_plo_y_in;
   logic [ptlp_pkg::DMAG_W+ptlp_pkg::THI_W-1:0] s4_phi_x_ff, s4_phi_x_in;
   logic [ptlp_pkg::DMAG_W+ptlp_pkg::THI_W-1:0] s4_phi_y_ff, s4_phi_y_in;
   logic [ptlp_pkg::DIFF_W-1:0]         neg_dx, neg_dy;
   logic [ptlp_pkg::DOT_W-1:0]          neg_t;
   logic [ptlp_pkg::DMAG_W-1:0]         dmag_x, dmag_y;
   logic [ptlp_pkg::TMAG_W-1:0]         tmag;

   // stage 5: numerators, divider entry
   logic                                s5_vld_ff;
   ptlp_pkg::ptlp_div_type              s5_ff, s5_in;
   logic [ptlp_pkg::NUM_W-1:0]          num_x, num_y;

   // divider output
   logic                                div_vld;
   ptlp_pkg::ptlp_div_type              div_out;

   // output register
   logic                                rsp_tvalid_ff;
   logic [CB-1:0]                       foot_x_ff, foot_x_in, foot_y_ff, foot_y_in;
   logic                                clipped_ff, clipped_in;
   logic [CB:0]                         axis_x, axis_y;

   // advance everything unless a result is held at the output
   assign pipe_en    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = pipe_en;

   always_comb begin
      s1_dx_in            = ptlp_pkg::DIFF_W'(req_ex) - ptlp_pkg::DIFF_W'(req_sx);
      s1_dy_in            = ptlp_pkg::DIFF_W'(req_ey) - ptlp_pkg::DIFF_W'(req_sy);
      s1_ux_in            = ptlp_pkg::DIFF_W'(req_px) - ptlp_pkg::DIFF_W'(req_sx);
      s1_uy_in            = ptlp_pkg::DIFF_W'(req_py) - ptlp_pkg::DIFF_W'(req_sy);
      s1_horiz_in         = (req_ey == req_sy);
      s1_side_in          = '0;
      s1_side_in.horiz    = s1_horiz_in;
      s1_side_in.start_x  = req_sx;
      s1_side_in.start_y  = req_sy;
      s1_side_in.point_x  = req_px;
   end

   always_comb begin
      s2_pxx_in = s1_ux_ff * s1_dx_ff;
      s2_pyy_in = s1_uy_ff * s1_dy_ff;
      s2_dxx_in = s1_dx_ff * s1_dx_ff;
      s2_dyy_in = s1_dy_ff * s1_dy_ff;
   end

   always_comb begin
      s3_t_in   = ptlp_pkg::DOT_W'(s2_pxx_ff) + ptlp_pkg::DOT_W'(s2_pyy_ff);
      den_sum   = {1'b0, s2_dxx_ff[ptlp_pkg::PROD_W-2:0]}
                + {1'b0, s2_dyy_ff[ptlp_pkg::PROD_W-2:0]};
      s3_den_in = den_sum[ptlp_pkg::DEN_W-1:0];
   end

   always_comb begin
      neg_dx  = -s3_dx_ff;
      neg_dy  = -s3_dy_ff;
      neg_t   = -s3_t_ff;
      dmag_x  = s3_dx_ff[ptlp_pkg::DIFF_W-1] ? neg_dx[ptlp_pkg::DMAG_W-1:0]
                                             : s3_dx_ff[ptlp_pkg::DMAG_W-1:0];
      dmag_y  = s3_dy_ff[ptlp_pkg::DIFF_W-1] ? neg_dy[ptlp_pkg::DMAG_W-1:0]
                                             : s3_dy_ff[ptlp_pkg::DMAG_W-1:0];
      tmag    = s3_t_ff[ptlp_pkg::DOT_W-1] ? neg_t[ptlp_pkg::TMAG_W-1:0]
                                           : s3_t_ff[ptlp_pkg::TMAG_W-1:0];
      s4_plo_x_in = dmag_x * tmag[ptlp_pkg::TLO_W-1:0];
      s4_phi_x_in = dmag_x * tmag[ptlp_pkg::TMAG_W-1:ptlp_pkg::TLO_W];
      s4_plo_y_in = dmag_y * tmag[ptlp_pkg::TLO_W-1:0];
      s4_phi_y_in = dmag_y * tmag[ptlp_pkg::TMAG_W-1:ptlp_pkg::TLO_W];
      s4_side_in       = s3_side_ff;
      s4_side_in.neg_x = s3_dx_ff[ptlp_pkg::DIFF_W-1] ^ s3_t_ff[ptlp_pkg::DOT_W-1];
      s4_side_in.neg_y = s3_dy_ff[ptlp_pkg::DIFF_W-1] ^ s3_t_ff[ptlp_pkg::DOT_W-1];
   end

   always_comb begin
      num_x = ptlp_pkg::NUM_W'(s4_plo_x_ff) + {s4_phi_x_ff, {ptlp_pkg::TLO_W{1'b0}}};
      num_y = ptlp_pkg::NUM_W'(s4_plo_y_ff) + {s4_phi_y_ff, {ptlp_pkg::TLO_W{1'b0}}};
      // the top bits of the numerator already sit below the divisor
      s5_in.rem_x = num_x[ptlp_pkg::NUM_W-1:ptlp_pkg::QUO_W];
      s5_in.low_x = num_x[ptlp_pkg::QUO_W-1:0];
      s5_in.rem_y = num_y[ptlp_pkg::NUM_W-1:ptlp_pkg::QUO_W];
      s5_in.low_y = num_y[ptlp_pkg::QUO_W-1:0];
      s5_in.den   = s4_den_ff;
      s5_in.side  = s4_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_vld_ff <= req_tvalid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_side_ff  <= s1_side_in;
         s1_dx_ff    <= s1_dx_in;
         s1_dy_ff    <= s1_dy_in;
         s1_ux_ff    <= s1_ux_in;
         s1_uy_ff    <= s1_uy_in;

         s2_side_ff  <= s1_side_ff;
         s2_dx_ff    <= s1_dx_ff;
         s2_dy_ff    <= s1_dy_ff;
         s2_pxx_ff   <= s2_pxx_in;
         s2_pyy_ff   <= s2_pyy_in;
         s2_dxx_ff   <= s2_dxx_in;
         s2_dyy_ff   <= s2_dyy_in;

         s3_side_ff  <= s2_side_ff;
         s3_dx_ff    <= s2_dx_ff;
         s3_dy_ff    <= s2_dy_ff;
         s3_t_ff     <= s3_t_in;
         s3_den_ff   <= s3_den_in;

         s4_side_ff  <= s4_side_in;
         s4_den_ff   <= s3_den_ff;
         s4_plo_x_ff <= s4_plo_x_in;
         s4_phi_x_ff <= s4_phi_x_in;
         s4_plo_y_ff <= s4_plo_y_in;
         s4_phi_y_ff <= s4_phi_y_in;

         s5_ff       <= s5_in;
      end
   end

   ptlp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_en),
      .in_valid  (s5_vld_ff),
      .in_data   (s5_ff),
      .out_valid (div_vld),
      .out_data  (div_out)
   );

   always_comb begin
      axis_x = foot_axis(div_out.side.start_x, div_out.low_x, |div_out.rem_x,
                         div_out.side.neg_x);
      axis_y = foot_axis(div_out.side.start_y, div_out.low_y, |div_out.rem_y,
                         div_out.side.neg_y);
      if (div_out.side.horiz) begin
         foot_x_in  = div_out.side.point_x;
         foot_y_in  = div_out.side.start_y;
         clipped_in = 1'b0;
      end else begin
         foot_x_in  = axis_x[CB-1:0];
         foot_y_in  = axis_y[CB-1:0];
         clipped_in = axis_x[CB] | axis_y[CB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_tvalid_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         foot_x_ff  <= foot_x_in;
         foot_y_ff  <= foot_y_in;
         clipped_ff <= clipped_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(ptlp_pkg::RSP_W - 2*CB - 1){1'b0}}, clipped_ff, foot_y_ff, foot_x_ff};

`ifndef SYNTH
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable({s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, div_vld}))
      else $error("pipeline valid bits moved during a stall");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (div_vld && !div_out.side.horiz) |->
         (div_out.rem_x < div_out.den) && (div_out.rem_y < div_out.den))
      else $error("divider remainder not below divisor");

   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && clipped_ff) |->
         (foot_x_ff == ptlp_pkg::FOOT_MAX[CB-1:0]) || (foot_x_ff == ptlp_pkg::FOOT_MIN[CB-1:0]) ||
         (foot_y_ff == ptlp_pkg::FOOT_MAX[CB-1:0]) || (foot_y_ff == ptlp_pkg::FOOT_MIN[CB-1:0]))
      else $error("clipped result not at a range bound");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid_ff)
      else $error("result valid straight after reset");
`endif

endmodule
